/* rtl/core/sem_pkg.sv */
// Shared types and constants for the RGB Sobel edge magnitude block.
`default_nettype none
package sem_pkg;

  // One window column of three pixels: index 0 is the top row, 2 the bottom row.
  typedef logic [2:0][23:0] col_t;

  // Command codes of the input beat.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // Magnitude saturation: above this sum of squares the result clips.
  localparam logic [20:0] SAT_LIMIT = 21'd65280;
  localparam logic [7:0]  MAG_MAX   = 8'd255;

  // Configuration register indexes.
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

endpackage
`default_nettype wire

/* rtl/core/sem_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module sem_ram #(
  parameter int Width = 48,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* rtl/core/sem_mag.sv */
// Iterative Sobel gradient and rounded square root for one 3x3 RGB window.
`default_nettype none
module sem_mag (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire sem_pkg::col_t [2:0] cols_i,
  output logic                     done_o,
  output logic [23:0]              res_o
);
  import sem_pkg::*;

  typedef enum logic [1:0] {M_IDLE, M_SQ, M_ITER, M_RND} mstate_e;

  mstate_e            state_q;
  logic signed [10:0] gx_q [3];
  logic signed [10:0] gy_q [3];
  logic signed [10:0] gx_d [3];
  logic signed [10:0] gy_d [3];
  logic [20:0]        s_q [3];
  logic [20:0]        s_d [3];
  logic [7:0]         n_q [3];
  logic [7:0]         n_d [3];
  logic [7:0]         r_d [3];
  logic [2:0]         b_q;
  logic               done_q;
  logic [23:0]        res_q;

  // Gradients of each channel from the nine window pixels.
  always_comb begin
    logic signed [10:0] v [3][3];
    for (int ch = 0; ch < 3; ch++) begin
      for (int cc = 0; cc < 3; cc++) begin
        for (int rr = 0; rr < 3; rr++) begin
          v[cc][rr] = $signed({3'b000, cols_i[cc][rr][ch*8 +: 8]});
        end
      end
      gx_d[ch] = (v[2][0] + (v[2][1] <<< 1) + v[2][2])
               - (v[0][0] + (v[0][1] <<< 1) + v[0][2]);
      gy_d[ch] = (v[0][2] + (v[1][2] <<< 1) + v[2][2])
               - (v[0][0] + (v[1][0] <<< 1) + v[2][0]);
    end
  end

  // Sum of squares, one square root bit per step, and the final rounding.
  always_comb begin
    logic signed [21:0] sqx;
    logic signed [21:0] sqy;
    logic [21:0]        tsum;
    logic [7:0]         t;
    logic [15:0]        tt;
    logic [16:0]        nn;
    for (int ch = 0; ch < 3; ch++) begin
      sqx = gx_q[ch] * gx_q[ch];
      sqy = gy_q[ch] * gy_q[ch];
      tsum = sqx + sqy;
      s_d[ch] = tsum[20:0];
      t = n_q[ch] | (8'd1 << b_q);
      tt = t * t;
      n_d[ch] = ({5'b0, tt} <= s_q[ch]) ? t : n_q[ch];
      nn = 17'(n_q[ch]) * 17'(n_q[ch]) + 17'(n_q[ch]);
      if (s_q[ch] > SAT_LIMIT) begin
        r_d[ch] = MAG_MAX;
      end else if (s_q[ch] > {4'b0, nn}) begin
        r_d[ch] = n_q[ch] + 8'd1;
      end else begin
        r_d[ch] = n_q[ch];
      end
    end
  end

  // Sequencer of the magnitude unit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      done_q  <= 1'b0;
      b_q     <= 3'd7;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        M_IDLE: begin
          if (start_i) begin
            gx_q    <= gx_d;
            gy_q    <= gy_d;
            state_q <= M_SQ;
          end
        end
        M_SQ: begin
          s_q     <= s_d;
          n_q     <= '{8'd0, 8'd0, 8'd0};
          b_q     <= 3'd7;
          state_q <= M_ITER;
        end
        M_ITER: begin
          n_q <= n_d;
          b_q <= b_q - 3'd1;
          if (b_q == 3'd0) begin
            state_q <= M_RND;
          end
        end
        M_RND: begin
          // Channel 0 sits in the low byte, so red comes from channel 2.
          res_q   <= {r_d[2], r_d[1], r_d[0]};
          done_q  <= 1'b1;
          state_q <= M_IDLE;
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_done_after_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q) == M_RND) else $error("done without rounding step");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == M_IDLE && start_i) |=> state_q == M_SQ) else $error("start lost");
  a_iter_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == M_ITER && b_q == 3'd0) |=> state_q == M_RND) else $error("iteration overrun");

endmodule
`default_nettype wire

/* rtl/core/sobel_edge_magnitude_rgb.sv */
// Top level of the streaming 3x3 Sobel gradient magnitude for RGB frames.
//
// Pixels enter in raster order on the input channel (valid/stall); each beat
// carries a command bit and the three 8-bit channels. A pixel beat of row r,
// column c yields the result of row r-1, column c-1, and the last pixel of a
// row also yields the row's last column. Drain beats flush the final row, one
// result per drain; the last one carries frame_last.
// One beat is worked on at a time. A pixel beat is accepted, then reads and
// updates the line memory; each result then passes through the shared
// magnitude unit (gradient, squares, eight root steps, rounding, hand-off).
// A drain beat first reads three line entries.
// Results sit in an output register; a stalled receiver holds it, and the
// input stays stalled while a beat is processed or its result waits for room.
// Reset sets width 1024 and height 768 and clears counters and window; the
// line memory is left as is. A configuration write restarts the frame.
`default_nettype none
module sobel_edge_magnitude_rgb #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [11:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        command_i,
  input  wire logic [7:0]  red_in_i,
  input  wire logic [7:0]  green_in_i,
  input  wire logic [7:0]  blue_in_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       red_out_o,
  output logic [7:0]       green_out_o,
  output logic [7:0]       blue_out_o,
  output logic             frame_last_o
);
  import sem_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  typedef enum logic [2:0] {ST_IDLE, ST_PX, ST_DR, ST_CALC, ST_WAIT, ST_PUSH} state_e;

  state_e         state_q;
  logic [10:0]    width_q;
  logic [11:0]    height_q;
  logic [AW-1:0]  col_q;
  logic [11:0]    row_q;
  logic [WW-1:0]  pend_q;
  col_t           wl_q;
  col_t           wc_q;
  col_t           x_q [3];
  logic [23:0]    px_q;
  logic [AW-1:0]  c_q;
  logic [WW-1:0]  k_q;
  logic [1:0]     dj_q;
  logic           rdv_q;
  logic           sel_q;
  logic           sec_q;
  logic           last_q;
  logic [23:0]    res_q;
  logic           out_valid_q;
  logic [23:0]    out_q;
  logic           out_last_q;

  logic [WW-1:0]  w_eff;
  logic [11:0]    h_eff;
  logic [AW-1:0]  c_eff;
  logic [WW-1:0]  p_eff;
  logic [WW:0]    dx;
  logic           dx_ok;
  logic           ram_we;
  logic [AW-1:0]  ram_raddr;
  logic [47:0]    ram_rdata;
  col_t           nc;
  col_t           wl_n;
  col_t           wc_n;
  col_t [2:0]     mag_cols;
  logic           mag_start;
  logic           mag_done;
  logic [23:0]    mag_res;
  logic           out_free;

  // Effective frame size and clamped counters.
  always_comb begin
    if (width_q == 11'd0) begin
      w_eff = WW'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    h_eff = (height_q == 12'd0) ? 12'd1 : height_q;
    c_eff = ({1'b0, col_q} >= (WW + 1)'(w_eff)) ? AW'(w_eff - WW'(1)) : col_q;
    p_eff = (pend_q > w_eff) ? w_eff : pend_q;
  end

  // Drain read position and whether it lies inside the row.
  assign dx    = (WW + 1)'(k_q) + (WW + 1)'(dj_q);
  assign dx_ok = (dx != '0) && (dx <= (WW + 1)'(w_eff));

  always_comb begin
    case (state_q)
      ST_DR:   ram_raddr = AW'(dx - (WW + 1)'(1));
      default: ram_raddr = c_eff;
    endcase
  end

  // New window column from the line memory and the incoming pixel.
  always_comb begin
    nc[0] = (row_q == 12'd0) ? 24'd0 : ram_rdata[47:24];
    nc[1] = (row_q == 12'd0) ? 24'd0 : ram_rdata[23:0];
    nc[2] = px_q;
    wl_n  = (c_q == '0) ? '0 : wl_q;
    wc_n  = (c_q == '0) ? '0 : wc_q;
  end

  assign ram_we = (state_q == ST_PX);

  sem_ram #(.Width(48), .Depth(MAX_WIDTH)) u_line (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (c_q),
    .wdata_i ({nc[1], px_q}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Window for the magnitude unit: left-center-right, or shifted for the row end.
  always_comb begin
    if (sel_q) begin
      mag_cols = {col_t'('0), x_q[2], x_q[1]};
    end else begin
      mag_cols = {x_q[2], x_q[1], x_q[0]};
    end
  end

  assign mag_start = (state_q == ST_CALC);

  sem_mag u_mag (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mag_start),
    .cols_i  (mag_cols),
    .done_o  (mag_done),
    .res_o   (mag_res)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Beat sequencer, frame counters, window and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      width_q     <= 11'd1024;
      height_q    <= 12'd768;
      col_q       <= '0;
      row_q       <= '0;
      pend_q      <= '0;
      wl_q        <= '0;
      wc_q        <= '0;
      dj_q        <= '0;
      rdv_q       <= 1'b0;
      sel_q       <= 1'b0;
      sec_q       <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // The output beat leaves unless a new result takes its place.
      if (out_valid_q && !out_stall_i && state_q != ST_PUSH) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            if (command_i == CMD_DRAIN) begin
              if (pend_q != '0) begin
                k_q    <= w_eff - p_eff;
                pend_q <= p_eff - WW'(1);
                last_q <= (p_eff == WW'(1));
                dj_q   <= '0;
                if (p_eff == WW'(1)) begin
                  col_q <= '0;
                  row_q <= '0;
                  wl_q  <= '0;
                  wc_q  <= '0;
                end
                state_q <= ST_DR;
              end
            end else if (pend_q == '0) begin
              px_q    <= {red_in_i, green_in_i, blue_in_i};
              c_q     <= c_eff;
              state_q <= ST_PX;
            end
          end
        end
        ST_PX: begin
          x_q[0] <= wl_n;
          x_q[1] <= wc_n;
          x_q[2] <= nc;
          wl_q   <= wc_n;
          wc_q   <= nc;
          last_q <= 1'b0;
          if ((WW + 1)'(c_q) + (WW + 1)'(1) >= (WW + 1)'(w_eff)) begin
            col_q <= '0;
            if (13'(row_q) + 13'd1 >= 13'(h_eff)) begin
              pend_q <= w_eff;
            end else begin
              row_q <= row_q + 12'd1;
            end
          end else begin
            col_q <= c_q + AW'(1);
          end
          if (row_q != 12'd0 && c_q != '0) begin
            sel_q   <= 1'b0;
            sec_q   <= (WW'(c_q) == w_eff - WW'(1));
            state_q <= ST_CALC;
          end else if (row_q != 12'd0 && WW'(c_q) == w_eff - WW'(1)) begin
            sel_q   <= 1'b1;
            sec_q   <= 1'b0;
            state_q <= ST_CALC;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_DR: begin
          rdv_q <= dx_ok;
          if (dj_q != 2'd0) begin
            x_q[dj_q - 2'd1] <= rdv_q ? {24'd0, ram_rdata[23:0], ram_rdata[47:24]} : '0;
          end
          dj_q <= dj_q + 2'd1;
          if (dj_q == 2'd3) begin
            sel_q   <= 1'b0;
            sec_q   <= 1'b0;
            state_q <= ST_CALC;
          end
        end
        ST_CALC: begin
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (mag_done) begin
            res_q   <= mag_res;
            state_q <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_q       <= res_q;
            out_last_q  <= last_q;
            if (!sel_q && sec_q) begin
              sel_q   <= 1'b1;
              sec_q   <= 1'b0;
              state_q <= ST_CALC;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      // A register write restarts the frame.
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_WIDTH) begin
          width_q <= cfg_data_i[10:0];
        end else begin
          height_q <= cfg_data_i;
        end
        col_q  <= '0;
        row_q  <= '0;
        pend_q <= '0;
        wl_q   <= '0;
        wc_q   <= '0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign red_out_o    = out_q[23:16];
  assign green_out_o  = out_q[15:8];
  assign blue_out_o   = out_q[7:0];
  assign frame_last_o = out_last_q;

  a_drain_resets_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != '0 |-> col_q == '0) else $error("column kept while draining");
  a_done_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mag_done |-> state_q == ST_WAIT) else $error("magnitude result unexpected");
  a_push_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PUSH && out_free) |=> out_valid_q) else $error("result lost");

endmodule
`default_nettype wire
